[hdl/cbc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the cluster buffer cache tag engine.
// No dependencies; used by the channel interface users and the top level.
package cbc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned TAG_W  = ADDR_W - OFF_W;
  localparam int unsigned DEV_W  = 4;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned BUSY_W = 8;
  localparam int unsigned VS_W   = 9;

  // Sectors per cluster is fixed at 2**OFF_W.
  localparam logic [VS_W-1:0]   VS_MAX   = VS_W'(2 ** OFF_W);
  localparam logic [BUSY_W-1:0] BUSY_MAX = '1;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_RELEASE = 2'd1,
    FN_PURGE   = 2'd2,
    FN_FILL    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_NOIDLE = 3'd2,
    ST_RDERR  = 3'd3,
    ST_UNDER  = 3'd4,
    ST_DONE   = 3'd5,
    ST_OVER   = 3'd6
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [DEV_W-1:0]    dev_id;
    logic [ADDR_W-1:0]   sector_addr;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    sector_count;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [OFF_W-1:0]    offset;
    logic [ADDR_W-1:0]   cluster_base;
  } rsp_t;

endpackage

[hdl/cbc_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one item of payload type T.
// No dependencies; the payload type is set where the channel is instantiated.
interface cbc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/cluster_buffer_cache_lru_top.sv]
`timescale 1ns / 1ps
// Tag and LRU replacement engine for a cache of 256-sector clusters.
// Depends on cbc_pkg, cbc_chan_if and cbc_slot_ram.
//
// One request is handled at a time; in_ch.ready is high only while the
// sequencer waits for work. All per-slot state lives in a slot table with one
// write port and one registered read port; the table is read one entry per
// cycle, and one compare/update unit walks over it. A get takes a full table
// scan plus a decide step and the output load, and a purge a full scan and
// the output load. A release reads the slot first and then ages every slot
// more recent than it in a second walk, or skips the walk when the slot is
// idle; a fill report reads and updates the slot, and walks the table as well
// only when a failed fill releases a busy slot. A release or fill report that
// names a slot past the table skips the read.
// Results sit in an output register, so a new request can be taken while
// the previous result waits for out_ch.ready. After reset the table is
// usable at once: unwritten slots read as invalid, idle, with rank equal to
// their index.
module cluster_buffer_cache_lru_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cbc_chan_if.sink    in_ch,
  cbc_chan_if.source  out_ch
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned XW = IW + cbc_pkg::SLOT_W;

  typedef logic [IW-1:0] idx_t;

  typedef struct packed {
    logic                        valid;
    logic [cbc_pkg::DEV_W-1:0]   dev;
    logic [cbc_pkg::TAG_W-1:0]   tag;
    logic [cbc_pkg::BUSY_W-1:0]  busy;
    logic [cbc_pkg::VS_W-1:0]    vs;
    idx_t                        rank;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_RD1, S_RD2, S_DECIDE, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SW_LOOKUP, SW_RECENT, SW_PURGE
  } sweep_t;

  function automatic logic [cbc_pkg::SLOT_W-1:0] slot4(idx_t i);
    logic [XW-1:0] x;
    x = XW'(i);
    return x[cbc_pkg::SLOT_W-1:0];
  endfunction

  state_t        state_r,      state_nxt;
  sweep_t        op_r,         op_nxt;
  cbc_pkg::req_t req_r,        req_nxt;
  logic [CW-1:0] cnt_r,        cnt_nxt;
  logic          rd_vld_r;
  idx_t          rd_idx_r;
  idx_t          tgt_r,        tgt_nxt;
  idx_t          rank_ref_r,   rank_ref_nxt;
  logic          hit_found_r,  hit_found_nxt;
  idx_t          hit_idx_r,    hit_idx_nxt;
  entry_t        hit_e_r,      hit_e_nxt;
  logic          idle_found_r, idle_found_nxt;
  idx_t          idle_idx_r,   idle_idx_nxt;
  idx_t          idle_rank_r,  idle_rank_nxt;
  cbc_pkg::rsp_t res_r,        res_nxt;
  cbc_pkg::rsp_t out_r,        out_nxt;
  logic          out_valid_r,  out_valid_nxt;

  cbc_pkg::req_t in_req;
  logic          we_c;
  idx_t          wa_c;
  entry_t        wd_c;
  logic          re_c;
  idx_t          ra_c;
  logic [EW-1:0] rdata;
  logic          rwritten;
  entry_t        e_c;
  entry_t        rst_e;

  logic [cbc_pkg::OFF_W-1:0]  off_c;
  logic [cbc_pkg::ADDR_W-1:0] base_c;
  logic [cbc_pkg::TAG_W-1:0]  tag_c;
  logic [XW-1:0]              slot_x;
  logic                       slot_ok;
  idx_t                       slot_idx;
  logic [cbc_pkg::VS_W-1:0]   cap_c;

  assign in_req = in_ch.data;

  assign off_c    = req_r.sector_addr[cbc_pkg::OFF_W-1:0];
  assign tag_c    = req_r.sector_addr[cbc_pkg::ADDR_W-1:cbc_pkg::OFF_W];
  assign base_c   = {tag_c, {cbc_pkg::OFF_W{1'b0}}};
  assign slot_x   = XW'(req_r.slot);
  assign slot_ok  = (slot_x < XW'(SLOTS));
  assign slot_idx = slot_x[IW-1:0];
  assign cap_c    = (req_r.sector_count > cbc_pkg::VS_MAX) ? cbc_pkg::VS_MAX
                                                           : req_r.sector_count;

  cbc_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_slot_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (we_c),
    .waddr    (wa_c),
    .wdata    (wd_c),
    .re       (re_c),
    .raddr    (ra_c),
    .rdata    (rdata),
    .rwritten (rwritten)
  );

  // Unwritten entries read as their reset contents.
  always_comb begin
    rst_e      = '0;
    rst_e.rank = rd_idx_r;
    e_c        = rwritten ? entry_t'(rdata) : rst_e;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    tgt_nxt        = tgt_r;
    rank_ref_nxt   = rank_ref_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_e_nxt      = hit_e_r;
    idle_found_nxt = idle_found_r;
    idle_idx_nxt   = idle_idx_r;
    idle_rank_nxt  = idle_rank_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    we_c           = 1'b0;
    wa_c           = rd_idx_r;
    wd_c           = e_c;
    re_c           = 1'b0;
    ra_c           = cnt_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt        = in_req;
          cnt_nxt        = '0;
          hit_found_nxt  = 1'b0;
          idle_found_nxt = 1'b0;
          case (in_req.func)
            cbc_pkg::FN_GET: begin
              op_nxt    = SW_LOOKUP;
              state_nxt = S_SWEEP;
            end
            cbc_pkg::FN_PURGE: begin
              op_nxt               = SW_PURGE;
              state_nxt            = S_SWEEP;
              res_nxt.status       = cbc_pkg::ST_DONE;
              res_nxt.slot_out     = '0;
              res_nxt.offset       = '0;
              res_nxt.cluster_base = '0;
            end
            default: begin
              state_nxt = S_RD1;
            end
          endcase
        end
      end

      S_RD1: begin
        res_nxt.slot_out = req_r.slot;
        if (req_r.func == cbc_pkg::FN_RELEASE) begin
          res_nxt.status       = cbc_pkg::ST_UNDER;
          res_nxt.offset       = '0;
          res_nxt.cluster_base = '0;
        end else begin
          res_nxt.status       = cbc_pkg::ST_RDERR;
          res_nxt.offset       = off_c;
          res_nxt.cluster_base = base_c;
        end
        if (!slot_ok) begin
          state_nxt = S_FINISH;
        end else begin
          re_c      = 1'b1;
          ra_c      = slot_idx;
          tgt_nxt   = slot_idx;
          state_nxt = S_RD2;
        end
      end

      S_RD2: begin
        wa_c         = tgt_r;
        wd_c         = e_c;
        rank_ref_nxt = e_c.rank;
        cnt_nxt      = '0;
        state_nxt    = S_FINISH;
        if (req_r.func == cbc_pkg::FN_RELEASE) begin
          if (e_c.busy != '0) begin
            we_c           = 1'b1;
            wd_c.busy      = e_c.busy - cbc_pkg::BUSY_W'(1);
            wd_c.rank      = '0;
            res_nxt.status = cbc_pkg::ST_DONE;
            op_nxt         = SW_RECENT;
            state_nxt      = S_SWEEP;
          end
        end else if (req_r.sector_count == '0) begin
          // Failed fill: drop the entry, release it if it was held.
          we_c       = 1'b1;
          wd_c.valid = 1'b0;
          if (e_c.busy != '0) begin
            wd_c.busy = e_c.busy - cbc_pkg::BUSY_W'(1);
            wd_c.rank = '0;
            op_nxt    = SW_RECENT;
            state_nxt = S_SWEEP;
          end
        end else begin
          we_c    = 1'b1;
          wd_c.vs = cap_c;
          if (cap_c <= cbc_pkg::VS_W'(off_c)) begin
            if (e_c.busy != '0) begin
              wd_c.busy = e_c.busy - cbc_pkg::BUSY_W'(1);
            end
          end else begin
            res_nxt.status = cbc_pkg::ST_DONE;
          end
        end
      end

      S_SWEEP: begin
        if (cnt_r < CW'(SLOTS)) begin
          re_c    = 1'b1;
          ra_c    = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          case (op_r)
            SW_LOOKUP: begin
              if (e_c.valid && (e_c.dev == req_r.dev_id) && (e_c.tag == tag_c) &&
                  (!hit_found_r || (e_c.rank < hit_e_r.rank))) begin
                hit_found_nxt = 1'b1;
                hit_idx_nxt   = rd_idx_r;
                hit_e_nxt     = e_c;
              end
              if ((e_c.busy == '0) && (!idle_found_r || (e_c.rank > idle_rank_r))) begin
                idle_found_nxt = 1'b1;
                idle_idx_nxt   = rd_idx_r;
                idle_rank_nxt  = e_c.rank;
              end
            end
            SW_RECENT: begin
              // Age every slot that was more recent than the one released.
              if ((rd_idx_r != tgt_r) && (e_c.rank < rank_ref_r)) begin
                we_c      = 1'b1;
                wd_c.rank = e_c.rank + idx_t'(1);
              end
            end
            SW_PURGE: begin
              if (e_c.dev == req_r.dev_id) begin
                we_c       = 1'b1;
                wd_c.valid = 1'b0;
                wd_c.busy  = '0;
              end
            end
            default: begin
            end
          endcase
          if (rd_idx_r == idx_t'(SLOTS - 1)) begin
            state_nxt = (op_r == SW_LOOKUP) ? S_DECIDE : S_FINISH;
          end
        end
      end

      S_DECIDE: begin
        res_nxt.offset       = off_c;
        res_nxt.cluster_base = base_c;
        state_nxt            = S_FINISH;
        if (hit_found_r) begin
          res_nxt.slot_out = slot4(hit_idx_r);
          wa_c             = hit_idx_r;
          wd_c             = hit_e_r;
          if (hit_e_r.busy == cbc_pkg::BUSY_MAX) begin
            res_nxt.status = cbc_pkg::ST_OVER;
          end else if (hit_e_r.vs <= cbc_pkg::VS_W'(off_c)) begin
            res_nxt.status = cbc_pkg::ST_RDERR;
          end else begin
            we_c           = 1'b1;
            wd_c.busy      = hit_e_r.busy + cbc_pkg::BUSY_W'(1);
            res_nxt.status = cbc_pkg::ST_HIT;
          end
        end else if (!idle_found_r) begin
          res_nxt.status   = cbc_pkg::ST_NOIDLE;
          res_nxt.slot_out = '0;
        end else begin
          // Claim the least recent idle slot; its rank stays.
          we_c             = 1'b1;
          wa_c             = idle_idx_r;
          wd_c.valid       = 1'b1;
          wd_c.dev         = req_r.dev_id;
          wd_c.tag         = tag_c;
          wd_c.busy        = cbc_pkg::BUSY_W'(1);
          wd_c.vs          = '0;
          wd_c.rank        = idle_rank_r;
          res_nxt.status   = cbc_pkg::ST_MISS;
          res_nxt.slot_out = slot4(idle_idx_r);
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_vld_r     <= re_c;
      rd_idx_r     <= ra_c;
      op_r         <= op_nxt;
      req_r        <= req_nxt;
      cnt_r        <= cnt_nxt;
      tgt_r        <= tgt_nxt;
      rank_ref_r   <= rank_ref_nxt;
      hit_found_r  <= hit_found_nxt;
      hit_idx_r    <= hit_idx_nxt;
      hit_e_r      <= hit_e_nxt;
      idle_found_r <= idle_found_nxt;
      idle_idx_r   <= idle_idx_nxt;
      idle_rank_r  <= idle_rank_nxt;
      res_r        <= res_nxt;
      out_r        <= out_nxt;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_recent_skips_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && op_r == SW_RECENT && we_c) |-> (wa_c != tgt_r))
    else $error("rank aging wrote the slot being made most recent");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start the sequencer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result register loaded outside the finish step");

  a_claim_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && !hit_found_r && we_c) |-> idle_found_r)
    else $error("slot claimed without an idle candidate");

endmodule

[hdl/cbc_slot_ram.sv]
`timescale 1ns / 1ps
// Slot table storage: one write port, one registered read port, and a
// written flag per entry so that unwritten entries can read as reset values.
module cbc_slot_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 52
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  output logic                     rwritten
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rwritten_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      rwritten_r <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      if (re) begin
        rwritten_r <= written_r[raddr];
      end
    end
  end

  assign rdata    = rdata_r;
  assign rwritten = rwritten_r;

endmodule
